@@ hdl/irc_pkg.sv @@
package irc_pkg;

	localparam int MAX_LINE_DEF = 510;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [7:0] CASE_OFFSET = 8'h20;
	localparam logic [7:0] PARAM_MAX = 8'hff;

	localparam logic [2:0] KIND_PREFIX = 3'd0;
	localparam logic [2:0] KIND_COMMAND = 3'd1;
	localparam logic [2:0] KIND_PARAM = 3'd2;
	localparam logic [2:0] KIND_TRAIL = 3'd3;
	localparam logic [2:0] KIND_PREFIX_CMD = 3'd4;
	localparam logic [2:0] KIND_END = 3'd5;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] out_byte;
		logic [7:0] upper_byte;
		logic       token_start;
		logic [7:0] param_index;
	} result_t;

	// one queue entry: an optional token result, then an optional end result
	typedef struct packed {
		logic    has_first;
		result_t first;
		logic    has_end;
	} entry_t;

	function automatic logic [7:0] to_upper(input logic [7:0] b);
		if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
			return b - CASE_OFFSET;
		end
		return b;
	endfunction

endpackage

@@ hdl/irc_rx_if.sv @@
interface irc_rx_if;
	logic       valid;
	logic       ready;
	logic       has_byte;
	logic [7:0] char_byte;
	logic       end_of_line;

	modport source (output valid, has_byte, char_byte, end_of_line, input ready);
	modport sink (input valid, has_byte, char_byte, end_of_line, output ready);
endinterface

@@ hdl/irc_tx_if.sv @@
interface irc_tx_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] out_byte;
	logic [7:0] upper_byte;
	logic       token_start;
	logic [7:0] param_index;
	logic       last;

	modport source (output valid, kind, out_byte, upper_byte, token_start, param_index, last,
		input ready);
	modport sink (input valid, kind, out_byte, upper_byte, token_start, param_index, last,
		output ready);
endinterface

@@ hdl/irc_front.sv @@
module irc_front #(
	parameter int MAX_LINE = irc_pkg::MAX_LINE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	irc_rx_if.sink          rx,
	input  logic            full,
	output logic            push,
	output irc_pkg::entry_t push_data
);
	import irc_pkg::*;

	localparam int PW = $clog2(MAX_LINE + 1);

	typedef enum logic [2:0] {
		M_START,
		M_PREFIX,
		M_CMD_SKIP,
		M_CMD,
		M_PARAM_SKIP,
		M_PARAM,
		M_TRAIL
	} mode_t;

	mode_t         mode_q, mode_n;
	logic [PW-1:0] pos_q, pos_n;
	logic          space_q, space_n;
	logic [7:0]    pcount_q, pcount_n;
	logic          accept;
	logic          take;
	logic [7:0]    up;
	entry_t        ent;

	// a held space closes the current token
	function automatic mode_t resolve(input mode_t m, input logic sp);
		if (!sp) begin
			return m;
		end
		if (m == M_PREFIX) begin
			return M_CMD_SKIP;
		end
		if (m == M_CMD || m == M_PARAM) begin
			return M_PARAM_SKIP;
		end
		return m;
	endfunction

	assign rx.ready = !full;
	assign accept = rx.valid && !full;
	assign take = rx.has_byte && (pos_q < PW'(MAX_LINE));
	assign up = to_upper(rx.char_byte);

	always_comb begin
		mode_n = mode_q;
		pos_n = pos_q;
		space_n = space_q;
		pcount_n = pcount_q;
		ent = '0;
		if (take) begin
			pos_n = pos_q + 1'b1;
			if (mode_q == M_TRAIL) begin
				ent.has_first = 1'b1;
				ent.first = '{KIND_TRAIL, rx.char_byte, up, 1'b0, 8'd0};
			end else if (rx.char_byte == CHAR_SPACE) begin
				mode_n = (mode_q == M_START) ? M_CMD_SKIP : resolve(mode_q, space_q);
				space_n = 1'b1;
			end else if (space_q && rx.char_byte == CHAR_COLON) begin
				space_n = 1'b0;
				if (mode_q == M_PREFIX) begin
					ent.has_first = 1'b1;
					ent.first = '{KIND_PREFIX_CMD, 8'd0, 8'd0, 1'b0, 8'd0};
				end
				mode_n = M_TRAIL;
			end else begin
				mode_n = resolve(mode_q, space_q);
				space_n = 1'b0;
				unique case (mode_n)
					M_START: begin
						if (rx.char_byte == CHAR_COLON) begin
							mode_n = M_PREFIX;
						end else begin
							mode_n = M_CMD;
							ent.has_first = 1'b1;
							ent.first = '{KIND_COMMAND, up, up, 1'b1, 8'd0};
						end
					end
					M_PREFIX: begin
						// a prefix byte that ends the line is carried by the re-tag result
						if (!rx.end_of_line) begin
							ent.has_first = 1'b1;
							ent.first = '{KIND_PREFIX, rx.char_byte, up,
								pos_q == PW'(1), 8'd0};
						end
					end
					M_CMD_SKIP: begin
						mode_n = M_CMD;
						ent.has_first = 1'b1;
						ent.first = '{KIND_COMMAND, up, up, 1'b1, 8'd0};
					end
					M_CMD: begin
						ent.has_first = 1'b1;
						ent.first = '{KIND_COMMAND, up, up, 1'b0, 8'd0};
					end
					M_PARAM_SKIP: begin
						mode_n = M_PARAM;
						ent.has_first = 1'b1;
						ent.first = '{KIND_PARAM, rx.char_byte, up, 1'b1, pcount_q};
						if (pcount_q != PARAM_MAX) begin
							pcount_n = pcount_q + 8'd1;
						end
					end
					default: begin
						ent.has_first = 1'b1;
						ent.first = '{KIND_PARAM, rx.char_byte, up, 1'b0,
							(pcount_q == 8'd0) ? 8'd0 : pcount_q - 8'd1};
					end
				endcase
			end
		end
		if (rx.end_of_line) begin
			if (resolve(mode_n, space_n) == M_PREFIX) begin
				ent.has_first = 1'b1;
				if (take && mode_q == M_PREFIX && !space_q && rx.char_byte != CHAR_SPACE) begin
					ent.first = '{KIND_PREFIX_CMD, rx.char_byte, up, 1'b1, 8'd0};
				end else begin
					ent.first = '{KIND_PREFIX_CMD, 8'd0, 8'd0, 1'b0, 8'd0};
				end
			end
			ent.has_end = 1'b1;
			mode_n = M_START;
			pos_n = '0;
			space_n = 1'b0;
			pcount_n = 8'd0;
		end
	end

	assign push = accept && (ent.has_first || ent.has_end);
	assign push_data = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_START;
			pos_q <= '0;
			space_q <= 1'b0;
			pcount_q <= 8'd0;
		end else if (accept) begin
			mode_q <= mode_n;
			pos_q <= pos_n;
			space_q <= space_n;
			pcount_q <= pcount_n;
		end
	end

	a_trail_no_space: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_TRAIL |-> !space_q)
		else $error("space held while in trailing text");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(MAX_LINE))
		else $error("byte position past line limit");

endmodule

@@ hdl/irc_fifo.sv @@
module irc_fifo #(
	parameter int DEPTH = irc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  irc_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output irc_pkg::entry_t head,
	output logic            empty
);
	import irc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into a full queue");

endmodule

@@ hdl/irc_back.sv @@
module irc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  irc_pkg::entry_t head,
	input  logic            empty,
	output logic            pop,
	irc_tx_if.source        tx
);
	import irc_pkg::*;

	logic    out_valid_q;
	result_t res_q;
	logic    last_q;
	logic    phase_q, phase_n;
	logic    load;
	logic    emit;
	result_t res_n;
	logic    last_n;

	assign load = !out_valid_q || tx.ready;
	assign emit = load && !empty;

	// phase 0 sends the token result, phase 1 the end of message
	always_comb begin
		pop = 1'b0;
		phase_n = phase_q;
		res_n = '{KIND_END, 8'd0, 8'd0, 1'b0, 8'd0};
		last_n = 1'b1;
		if (emit) begin
			if (head.has_first && !phase_q) begin
				res_n = head.first;
				last_n = !head.has_end;
				if (head.has_end) begin
					phase_n = 1'b1;
				end else begin
					pop = 1'b1;
				end
			end else begin
				pop = 1'b1;
				phase_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !empty;
			end
			phase_q <= phase_n;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_n;
			last_q <= last_n;
		end
	end

	assign tx.valid = out_valid_q;
	assign tx.kind = res_q.kind;
	assign tx.out_byte = res_q.out_byte;
	assign tx.upper_byte = res_q.upper_byte;
	assign tx.token_start = res_q.token_start;
	assign tx.param_index = res_q.param_index;
	assign tx.last = last_q;

	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q && last_q)
		else $error("entry retired without a closing beat");

	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> !empty && head.has_end && head.has_first)
		else $error("end phase without a matching queue entry");

	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		emit && phase_q |=> res_q.kind == KIND_END)
		else $error("end phase emitted a token result");

endmodule

@@ hdl/irc_line_tokenizer.sv @@
// irc line tokenizer
// rx carries one item a beat: has_byte/char_byte is the next byte of a message line,
// end_of_line closes the line (with or without a byte). tx carries the tagged results:
// prefix, command, parameter and trailing bytes, the prefix-is-command marker and the
// end-of-message result; last marks the final result of one rx item.
// the front classifies every accepted item in the cycle it arrives and writes zero or
// one queue entry (a token result and/or an end result); the back pulls entries from
// the queue and presents one result per cycle while tx is ready, from an output register.
// a result is registered in the queue and then in the output register before it is valid on tx.
// throughput: one item per cycle while items give at most one result and tx is ready;
// an item that gives two results occupies the output for both of them, and the queue of
// QUEUE_DEPTH entries absorbs the difference.
// bytes beyond MAX_LINE in one line are dropped without a result.
// when tx stalls the output register holds, the queue fills, and rx.ready drops only
// once the queue is full.
// reset clears the parse state to line start, empties the queue and drops tx.valid.
module irc_line_tokenizer #(
	parameter int MAX_LINE = irc_pkg::MAX_LINE_DEF,
	parameter int QUEUE_DEPTH = irc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	irc_rx_if.sink   rx,
	irc_tx_if.source tx
);
	import irc_pkg::*;

	logic   push;
	entry_t push_data;
	logic   full;
	logic   pop;
	entry_t head;
	logic   empty;

	irc_front #(
		.MAX_LINE(MAX_LINE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.full     (full),
		.push     (push),
		.push_data(push_data)
	);

	irc_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	irc_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.empty (empty),
		.pop   (pop),
		.tx    (tx)
	);

endmodule
